// ----- design/sac_pkg.sv -----
`timescale 1ns / 1ps

package sac_pkg;

    localparam int ADDR_W      = 64;
    localparam int TAG_W       = 63;
    localparam int CNT_W       = 32;
    localparam int OP_W        = 2;
    localparam int BLOCK_MAX   = 16;
    localparam int OUT_TDATA_W = 104;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        REG_SET_BITS   = 2'd0,
        REG_BLOCK_BITS = 2'd1,
        REG_WAYS       = 2'd2
    } t_reg;

    typedef struct packed {
        logic [3:0] set_bits;
        logic [4:0] block_bits;
        logic [3:0] ways;
    } t_cfg;

endpackage

// ----- design/sac_ram.sv -----
`timescale 1ns / 1ps

module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/sac_front.sv -----
`timescale 1ns / 1ps

module sac_front #(
    parameter int MAX_SET_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sac_pkg::t_cfg                i_cfg,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [sac_pkg::ADDR_W-1:0]   i_s_tdata,
    input  logic [sac_pkg::OP_W-1:0]     i_s_tuser,
    output logic                         o_q_valid,
    input  logic                         i_q_pop,
    output logic [MAX_SET_BITS-1:0]      o_q_set,
    output logic [sac_pkg::TAG_W-1:0]    o_q_tag,
    output logic                         o_q_two
);

    localparam logic [4:0] SMAX = 5'(MAX_SET_BITS);
    localparam logic [4:0] BMAX = 5'(sac_pkg::BLOCK_MAX);

    logic [4:0]                   s_eff;
    logic [4:0]                   b_eff;
    logic [5:0]                   sb;
    logic [sac_pkg::ADDR_W-1:0]   shifted;
    logic [sac_pkg::ADDR_W-1:0]   tag_full;
    logic [MAX_SET_BITS-1:0]      set_mask;
    logic [MAX_SET_BITS-1:0]      set_idx;
    logic                         op_ok;
    logic                         push;

    logic [MAX_SET_BITS-1:0]      r_q_set [2];
    logic [sac_pkg::TAG_W-1:0]    r_q_tag [2];
    logic                         r_q_two [2];
    logic                         r_wp;
    logic                         r_rp;
    logic [1:0]                   r_cnt;
    logic [1:0]                   n_cnt;

    always_comb begin
        s_eff = {1'b0, i_cfg.set_bits};
        if (s_eff == 5'd0) begin
            s_eff = 5'd1;
        end else if (s_eff > SMAX) begin
            s_eff = SMAX;
        end
        b_eff = i_cfg.block_bits;
        if (b_eff == 5'd0) begin
            b_eff = 5'd1;
        end else if (b_eff > BMAX) begin
            b_eff = BMAX;
        end
    end

    assign sb       = {1'b0, s_eff} + {1'b0, b_eff};
    assign shifted  = i_s_tdata >> b_eff;
    assign tag_full = i_s_tdata >> sb;
    assign set_mask = ~({MAX_SET_BITS{1'b1}} << s_eff);
    assign set_idx  = shifted[MAX_SET_BITS-1:0] & set_mask;

    assign op_ok = (i_s_tuser == sac_pkg::OP_LOAD) || (i_s_tuser == sac_pkg::OP_STORE)
                || (i_s_tuser == sac_pkg::OP_MODIFY);

    assign o_s_tready = (r_cnt != 2'd2);
    assign push       = i_s_tvalid && o_s_tready && op_ok;
    assign o_q_valid  = (r_cnt != 2'd0);

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_q_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_q_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_set[r_wp] <= set_idx;
            r_q_tag[r_wp] <= tag_full[sac_pkg::TAG_W-1:0];
            r_q_two[r_wp] <= (i_s_tuser == sac_pkg::OP_MODIFY);
        end
    end

    assign o_q_set = r_q_set[r_rp];
    assign o_q_tag = r_q_tag[r_rp];
    assign o_q_two = r_q_two[r_rp];

endmodule

// ----- design/sac_back.sv -----
`timescale 1ns / 1ps

module sac_back #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sac_pkg::t_cfg                     i_cfg,
    input  logic                              i_q_valid,
    output logic                              o_q_pop,
    input  logic [MAX_SET_BITS-1:0]           i_q_set,
    input  logic [sac_pkg::TAG_W-1:0]         i_q_tag,
    input  logic                              i_q_two,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [sac_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tlast
);

    localparam int TAG_W  = sac_pkg::TAG_W;
    localparam int CNT_W  = sac_pkg::CNT_W;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W  = WAY_W;
    localparam int LINE_W = TAG_W + 1 + AGE_W;
    localparam int ROW_W  = MAX_WAYS * LINE_W;
    localparam int SETS   = 1 << MAX_SET_BITS;
    localparam int NW_W   = $clog2(MAX_WAYS + 16);
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);
    localparam logic [NW_W-1:0]  NW_MAX  = NW_W'(MAX_WAYS);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_bstate;

    t_bstate r_state;
    t_bstate n_state;

    logic [MAX_SET_BITS-1:0] r_set;
    logic [TAG_W-1:0]        r_tag;
    logic                    r_two;
    logic                    r_second;
    logic [SETS-1:0]         r_rowv;
    logic [ROW_W-1:0]        r_row;
    logic [ROW_W-1:0]        n_row;
    logic [ROW_W-1:0]        rd_data;
    logic [ROW_W-1:0]        src_row;
    logic [ROW_W-1:0]        src_masked;
    logic                    src_ok;

    logic [WAY_W-1:0] r_way;
    logic             r_hit;
    logic             r_evict;
    logic             r_all;
    logic [AGE_W-1:0] r_lim;

    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;
    logic [CNT_W-1:0] r_evicts;
    logic [CNT_W-1:0] n_hits;
    logic [CNT_W-1:0] n_misses;
    logic [CNT_W-1:0] n_evicts;

    logic                             r_out_valid;
    logic [sac_pkg::OUT_TDATA_W-1:0]  r_out_data;
    logic                             r_out_last;

    logic [NW_W-1:0]    ways_eff;
    logic [MAX_WAYS-1:0] in_use;
    logic [TAG_W-1:0]   s_tag [MAX_WAYS];
    logic               s_vld [MAX_WAYS];
    logic [AGE_W-1:0]   s_age [MAX_WAYS];
    logic [TAG_W-1:0]   u_tag [MAX_WAYS];
    logic               u_vld [MAX_WAYS];
    logic [AGE_W-1:0]   u_age [MAX_WAYS];

    logic             c_hit;
    logic             c_found;
    logic [WAY_W-1:0] c_hway;
    logic [WAY_W-1:0] c_iway;
    logic [WAY_W-1:0] c_oway;
    logic [WAY_W-1:0] c_way;

    logic out_free;
    logic ram_re;
    logic ram_we;

    always_comb begin
        ways_eff = NW_W'(i_cfg.ways);
        if (ways_eff == '0) begin
            ways_eff = NW_W'(1);
        end else if (ways_eff > NW_MAX) begin
            ways_eff = NW_MAX;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            in_use[i] = (NW_W'(i) < ways_eff);
        end
    end

    sac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_set),
        .i_wdata (n_row),
        .i_re    (ram_re),
        .i_raddr (i_q_set),
        .o_rdata (rd_data)
    );

    // Rows never written read as all-invalid, age zero.
    assign src_row = r_second ? r_row : rd_data;
    assign src_ok  = r_second || r_rowv[r_set];

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            s_tag[i] = src_row[i*LINE_W + AGE_W + 1 +: TAG_W];
            s_vld[i] = src_row[i*LINE_W + AGE_W] & src_ok;
            s_age[i] = src_ok ? src_row[i*LINE_W +: AGE_W] : '0;
            src_masked[i*LINE_W +: LINE_W] = {s_tag[i], s_vld[i], s_age[i]};
        end
    end

    always_comb begin
        c_hit   = 1'b0;
        c_found = 1'b0;
        c_hway  = '0;
        c_iway  = '0;
        c_oway  = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (!c_hit && in_use[i] && s_vld[i] && (s_tag[i] == r_tag)) begin
                c_hit  = 1'b1;
                c_hway = WAY_W'(i);
            end
            if (!c_found && in_use[i] && !s_vld[i]) begin
                c_found = 1'b1;
                c_iway  = WAY_W'(i);
            end
        end
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (in_use[i] && (s_age[i] > s_age[c_oway])) begin
                c_oway = WAY_W'(i);
            end
        end
        c_way = c_hit ? c_hway : (c_found ? c_iway : c_oway);
    end

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            u_tag[i] = r_row[i*LINE_W + AGE_W + 1 +: TAG_W];
            u_vld[i] = r_row[i*LINE_W + AGE_W];
            u_age[i] = r_row[i*LINE_W +: AGE_W];
            if (WAY_W'(i) == r_way) begin
                u_age[i] = '0;
                if (!r_hit) begin
                    u_tag[i] = r_tag;
                    u_vld[i] = 1'b1;
                end
            end else if (in_use[i] && u_vld[i] && (r_all || (u_age[i] < r_lim))
                         && (u_age[i] < AGE_MAX)) begin
                u_age[i] = u_age[i] + AGE_W'(1);
            end
            n_row[i*LINE_W +: LINE_W] = {u_tag[i], u_vld[i], u_age[i]};
        end
    end

    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        n_evicts = r_evicts;
        if (r_hit) begin
            n_hits = (r_hits == CNT_MAX) ? r_hits : r_hits + CNT_W'(1);
        end else begin
            n_misses = (r_misses == CNT_MAX) ? r_misses : r_misses + CNT_W'(1);
        end
        if (r_evict) begin
            n_evicts = (r_evicts == CNT_MAX) ? r_evicts : r_evicts + CNT_W'(1);
        end
    end

    assign out_free = !r_out_valid || i_m_tready;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign ram_re   = o_q_pop;
    assign ram_we   = (r_state == S_UPD) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    n_state = (r_two && !r_second) ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rowv      <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_pop) begin
                r_second <= 1'b0;
            end
            if (ram_we) begin
                r_rowv[r_set] <= 1'b1;
                r_hits        <= n_hits;
                r_misses      <= n_misses;
                r_evicts      <= n_evicts;
                r_out_valid   <= 1'b1;
                if (r_two && !r_second) begin
                    r_second <= 1'b1;
                end
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_set <= i_q_set;
            r_tag <= i_q_tag;
            r_two <= i_q_two;
        end
        if (r_state == S_CMP) begin
            r_row   <= src_masked;
            r_way   <= c_way;
            r_hit   <= c_hit;
            r_evict <= !c_hit && !c_found;
            r_all   <= !c_hit && c_found;
            r_lim   <= s_age[c_way];
        end
        if (ram_we) begin
            r_row      <= n_row;
            r_out_last <= !r_two || r_second;
            r_out_data <= {6'b0, n_evicts, n_misses, n_hits, r_evict, r_hit};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// ----- design/set_assoc_lru_cache_lookup_core.sv -----
`timescale 1ns / 1ps
// Set-associative tag store with LRU replacement.
// Input stream: tdata = 64-bit byte address, tuser = op (load, store, modify).
// An op code outside those three is taken and dropped with no result.
// Output stream: one result per access, two for a modify; tlast marks the
// final one of each input. tdata carries hit, evicted and the three running
// saturating totals (hit, miss, eviction) as they stand after that access.
// Geometry (set bits, block bits, ways in use; reads return it) is written
// over APB at bytes 0, 4 and 8 by the user, only while the block is idle.
// A front stage splits the address into set and tag and queues up to two
// requests; the back stage reads the whole set from one RAM row, compares all
// ways in parallel, then writes the updated row back.
// The block does not enforce the idle rule. The back stage takes one access
// at a time: RAM read, compare, update; a modify repeats compare and update.
// Reset clears all line valid state (one flag per set), the totals and the
// output register; geometry returns to 1, 1, 1. No clearing pass is needed.
// A stalled output holds its result; the back stage then waits in its update
// step, and the input side backs up once the two-entry queue is full.

module set_assoc_lru_cache_lookup_core #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [sac_pkg::ADDR_W-1:0]          i_s_tdata,  // [63:0] address
    input  logic [sac_pkg::OP_W-1:0]            i_s_tuser,  // [1:0] op
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [0] hit, [1] evicted, [33:2] total_hits, [65:34] total_misses,
    // [97:66] total_evictions, [103:98] zero
    output logic [sac_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sac_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [sac_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sac_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    sac_pkg::t_cfg r_cfg;

    logic                          q_valid;
    logic                          q_pop;
    logic [MAX_SET_BITS-1:0]       q_set;
    logic [sac_pkg::TAG_W-1:0]     q_tag;
    logic                          q_two;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits   <= 4'd1;
            r_cfg.block_bits <= 5'd1;
            r_cfg.ways       <= 4'd1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                sac_pkg::REG_SET_BITS:   r_cfg.set_bits   <= pwdata[3:0];
                sac_pkg::REG_BLOCK_BITS: r_cfg.block_bits <= pwdata[4:0];
                sac_pkg::REG_WAYS:       r_cfg.ways       <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sac_pkg::REG_SET_BITS:   prdata = {28'b0, r_cfg.set_bits};
            sac_pkg::REG_BLOCK_BITS: prdata = {27'b0, r_cfg.block_bits};
            sac_pkg::REG_WAYS:       prdata = {28'b0, r_cfg.ways};
            default:                 prdata = '0;
        endcase
    end

    sac_front #(
        .MAX_SET_BITS (MAX_SET_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_set    (q_set),
        .o_q_tag    (q_tag),
        .o_q_two    (q_two)
    );

    sac_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_q_set    (q_set),
        .i_q_tag    (q_tag),
        .i_q_two    (q_two),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ----- design/sac_checker.sv -----
`timescale 1ns / 1ps

module sac_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic [sac_pkg::ADDR_W-1:0]          i_s_tdata,
    input logic [sac_pkg::OP_W-1:0]            i_s_tuser,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [sac_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    input logic                                o_m_tlast,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [sac_pkg::APB_ADDR_W-1:0]      paddr,
    input logic [sac_pkg::APB_DATA_W-1:0]      pwdata,
    input logic [sac_pkg::APB_DATA_W-1:0]      prdata,
    input logic                                pready
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> !o_m_tdata[1] && (o_m_tdata[33:2] != 32'd0))
        else $error("hit result inconsistent with totals");

    a_miss_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> (o_m_tdata[65:34] != 32'd0))
        else $error("miss result with zero miss total");

    a_evict_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1] |-> (o_m_tdata[97:66] != 32'd0))
        else $error("eviction result with zero eviction total");

endmodule

bind set_assoc_lru_cache_lookup_core sac_checker u_sac_checker (.*);
